// ===== design/kbrt_pkg.sv =====
// Shared types, constants and helpers of the k-bucket routing table.
`default_nettype none
package kbrt_pkg;

   localparam int NUM_BUCKETS_DEF = 160;
   localparam int MAX_K_DEF       = 8;
   localparam int BUCKET_W        = 8;
   localparam int ID_W            = 160;
   localparam int ADDR_W          = 48;
   localparam int FAIL_W          = 8;
   localparam int REQ_DATA_W      = 208;
   localparam int RSP_DATA_W      = 16;
   localparam int CSR_IDX_W       = 3;

   // request opcodes
   localparam logic [1:0] OP_SEEN   = 2'd0;
   localparam logic [1:0] OP_FAILED = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   // outcome codes
   localparam logic [3:0] OC_MOVED    = 4'd0;
   localparam logic [3:0] OC_INSERTED = 4'd1;
   localparam logic [3:0] OC_REPLACED = 4'd2;
   localparam logic [3:0] OC_CACHED   = 4'd3;
   localparam logic [3:0] OC_HAVE     = 4'd4;
   localparam logic [3:0] OC_IGNORED  = 4'd5;
   localparam logic [3:0] OC_COUNTED  = 4'd6;
   localparam logic [3:0] OC_EVICTED  = 4'd7;
   localparam logic [3:0] OC_SWAPPED  = 4'd8;
   localparam logic [3:0] OC_QUERY    = 4'd9;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_HI   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_MID  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_LO   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BKT_SIZE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FAIL = 3'd4;

   typedef struct packed {
      logic [ID_W-1:0]   own_id;
      logic [3:0]        bucket_size;
      logic [FAIL_W-1:0] max_fail;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [BUCKET_W-1:0] bucket;
      logic [ID_W-1:0]     id;
      logic [ADDR_W-1:0]   addr;
   } cmd_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] addr;
      logic [FAIL_W-1:0] fails;
   } live_entry_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [ADDR_W-1:0] addr;
   } spare_entry_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SCAN,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_CNT,
      B_CNTW,
      B_LOAD,
      B_LOADW,
      B_EXEC,
      B_WRITE,
      B_CLIMB,
      B_CLIMBW,
      B_DONE
   } back_state_type;

   // position of the highest set bit, 0 for a zero word
   function automatic logic [4:0] top_bit32(input logic [31:0] v);
      logic [4:0] r;
      r = '0;
      for (int i = 0; i < 32; i++) begin
         if (v[i]) r = 5'(i);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/kbucket_routing_table.sv =====
// Top level of the k-bucket routing table: configuration registers and wiring.
// The front end searches for the bucket 32 bits a cycle; the back end loads the bucket,
// applies the operation and writes it back, and after an eviction moves the lowest
// active bucket up past each empty bucket.  The back end takes one request from the
// queue at a time, and the next only after handing on the last.  Synchronous reset;
// bucket counts are cleared by per-bucket valid bits, no clearing pass.
`default_nettype none
module kbucket_routing_table #(
   parameter int NUM_BUCKETS = kbrt_pkg::NUM_BUCKETS_DEF,
   parameter int MAX_K       = kbrt_pkg::MAX_K_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [1:0]                         req_tuser,  // opcode
   // node_id_hi, node_id_mid, node_id_lo, peer_ip, peer_port
   input  wire logic [kbrt_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [kbrt_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // answer, lowest_active
   output logic [3:0]                              rsp_tuser,  // outcome
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [kbrt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [63:0]                        csr_wdata
);
   import kbrt_pkg::*;

   logic [63:0] own_hi_ff, own_hi_in, own_mid_ff, own_mid_in;
   logic [31:0] own_lo_ff, own_lo_in;
   logic [3:0]  bsize_ff, bsize_in;
   logic [7:0]  maxf_ff, maxf_in;
   cfg_type     cfg;
   logic        q_full, q_empty, q_push, q_pop;
   cmd_type     q_cmd, q_head;

   assign csr_ready = 1'b1;

   // register writes
   always_comb begin
      own_hi_in  = own_hi_ff;
      own_mid_in = own_mid_ff;
      own_lo_in  = own_lo_ff;
      bsize_in   = bsize_ff;
      maxf_in    = maxf_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_OWN_HI:   own_hi_in  = csr_wdata;
            CSR_OWN_MID:  own_mid_in = csr_wdata;
            CSR_OWN_LO:   own_lo_in  = csr_wdata[31:0];
            CSR_BKT_SIZE: bsize_in   = csr_wdata[3:0];
            CSR_MAX_FAIL: maxf_in    = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_hi_ff  <= '0;
         own_mid_ff <= '0;
         own_lo_ff  <= '0;
         bsize_ff   <= 4'd8;
         maxf_ff    <= 8'd20;
      end else begin
         own_hi_ff  <= own_hi_in;
         own_mid_ff <= own_mid_in;
         own_lo_ff  <= own_lo_in;
         bsize_ff   <= bsize_in;
         maxf_ff    <= maxf_in;
      end
   end

   assign cfg = '{own_id: {own_hi_ff, own_mid_ff, own_lo_ff},
                  bucket_size: bsize_ff, max_fail: maxf_ff};

   kbrt_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .own_id(cfg.own_id), .q_full(q_full), .q_push(q_push), .q_cmd(q_cmd));

   kbrt_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_cmd(q_cmd),
      .pop(q_pop), .full(q_full), .empty(q_empty), .head(q_head));

   kbrt_back #(.NUM_BUCKETS(NUM_BUCKETS), .MAX_K(MAX_K)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser));

endmodule
`default_nettype wire

// ===== design/kbrt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module kbrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/kbrt_front.sv =====
// Front end: takes requests and finds the bucket from the XOR distance.
`default_nettype none
module kbrt_front #(
   parameter int NUM_BUCKETS = kbrt_pkg::NUM_BUCKETS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [1:0]                        req_tuser,  // opcode
   input  wire logic [kbrt_pkg::REQ_DATA_W-1:0]   req_tdata,  // hi, mid, lo, ip, port
   input  wire logic [kbrt_pkg::ID_W-1:0]         own_id,
   input  wire logic                              q_full,
   output logic                                   q_push,
   output kbrt_pkg::cmd_type                      q_cmd
);
   import kbrt_pkg::*;

   front_state_type state_ff, state_in;
   logic [ID_W-1:0] x_ff, x_in;
   logic [2:0]      chunk_ff, chunk_in;
   cmd_type         cmd_ff, cmd_in;
   logic [31:0]     chunk_word;
   logic            chunk_hit;
   logic [BUCKET_W-1:0] raw_bucket;

   assign chunk_word = x_ff[32*chunk_ff +: 32];
   assign chunk_hit  = (chunk_word != '0) || (chunk_ff == '0);
   assign raw_bucket = {chunk_ff, top_bit32(chunk_word)};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: if (req_tvalid) state_in = F_SCAN;
         F_SCAN: if (chunk_hit) state_in = F_PUSH;
         F_PUSH: if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      q_push     = 1'b0;
      case (state_ff)
         F_IDLE: req_tready = 1'b1;
         F_PUSH: q_push = !q_full;
         default: ;
      endcase
   end

   // datapath: one 32-bit chunk of the distance per cycle, top chunk first
   always_comb begin
      x_in     = x_ff;
      chunk_in = chunk_ff;
      cmd_in   = cmd_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_tvalid) begin
               cmd_in.opcode = req_tuser;
               cmd_in.id     = req_tdata[159:0];
               cmd_in.addr   = {req_tdata[191:160], req_tdata[207:192]};
               cmd_in.bucket = '0;
               x_in          = {req_tdata[63:0], req_tdata[127:64], req_tdata[159:128]} ^ own_id;
               chunk_in      = 3'd4;
            end
         end
         F_SCAN: begin
            if (chunk_hit) begin
               cmd_in.bucket = (raw_bucket > BUCKET_W'(NUM_BUCKETS - 1)) ?
                               BUCKET_W'(NUM_BUCKETS - 1) : raw_bucket;
            end else begin
               chunk_in = chunk_ff - 3'd1;
            end
         end
         default: ;
      endcase
   end

   // node id is kept as {hi, mid, lo}
   always_comb begin
      q_cmd    = cmd_ff;
      q_cmd.id = {cmd_ff.id[63:0], cmd_ff.id[127:64], cmd_ff.id[159:128]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff     <= x_in;
      chunk_ff <= chunk_in;
      cmd_ff   <= cmd_in;
   end

endmodule
`default_nettype wire

// ===== design/kbrt_queue.sv =====
// Two-entry command queue between the front and back ends.
`default_nettype none
module kbrt_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  kbrt_pkg::cmd_type      push_cmd,
   input  wire logic              pop,
   output logic                   full,
   output logic                   empty,
   output kbrt_pkg::cmd_type      head
);
   import kbrt_pkg::*;

   cmd_type    mem_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) mem_ff[wptr_ff] <= push_cmd;
   end

endmodule
`default_nettype wire

// ===== design/kbrt_back.sv =====
// Back end: loads one bucket, applies the operation, writes it back.
`default_nettype none
module kbrt_back #(
   parameter int NUM_BUCKETS = kbrt_pkg::NUM_BUCKETS_DEF,
   parameter int MAX_K       = kbrt_pkg::MAX_K_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  kbrt_pkg::cfg_type                     cfg,
   input  wire logic                             q_empty,
   input  kbrt_pkg::cmd_type                     q_head,
   output logic                                  q_pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [kbrt_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // answer, lowest_active
   output logic [3:0]                            rsp_tuser   // outcome
);
   import kbrt_pkg::*;

   localparam int SPARE_K = MAX_K + 1;
   localparam int CNT_W   = $clog2(MAX_K + 2);
   localparam int LI_W    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int SI_W    = $clog2(SPARE_K);
   localparam int LA_W    = $clog2(NUM_BUCKETS * MAX_K);
   localparam int SA_W    = $clog2(NUM_BUCKETS * SPARE_K);
   localparam int CA_W    = $clog2(NUM_BUCKETS);
   localparam int H_W     = $clog2(NUM_BUCKETS * MAX_K + 1);
   localparam int LE_W    = $bits(live_entry_type);
   localparam int SE_W    = $bits(spare_entry_type);

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [SI_W-1:0] idx_ff, idx_in;
   logic           cap_vld_ff, cap_vld_in;
   logic [SI_W-1:0] cap_idx_ff, cap_idx_in;
   logic [CNT_W-1:0] lc_ff, lc_in, sc_ff, sc_in;
   logic           hit_ff, hit_in, shit_ff, shit_in;
   logic [LI_W-1:0] hidx_ff, hidx_in, best_ff, best_in;
   logic [FAIL_W-1:0] bestf_ff, bestf_in;
   live_entry_type  live_lane_ff [MAX_K];
   live_entry_type  live_lane_in [MAX_K];
   spare_entry_type spare_lane_ff [SPARE_K];
   spare_entry_type spare_lane_in [SPARE_K];
   logic           ldirty_ff, ldirty_in, sdirty_ff, sdirty_in, climb_ff, climb_in;
   logic [H_W-1:0] healthy_ff, healthy_in;
   logic [BUCKET_W-1:0] lowest_ff, lowest_in;
   logic           answer_ff, answer_in;
   logic [3:0]     outcome_ff, outcome_in;
   logic [NUM_BUCKETS-1:0] valid_ff, valid_in;
   logic           cvld_ff, cvld_in;
   logic           rsp_valid_ff, rsp_valid_in, rsp_answer_ff, rsp_answer_in;
   logic [3:0]     rsp_outcome_ff, rsp_outcome_in;
   logic [BUCKET_W-1:0] rsp_lowest_ff, rsp_lowest_in;

   // memory ports
   logic            lv_wr_en, lv_rd_en, sp_wr_en, sp_rd_en, ct_wr_en, ct_rd_en;
   logic [LA_W-1:0] lv_wr_addr, lv_rd_addr;
   logic [SA_W-1:0] sp_wr_addr, sp_rd_addr;
   logic [CA_W-1:0] ct_wr_addr, ct_rd_addr;
   logic [LE_W-1:0] lv_rd_data;
   logic [SE_W-1:0] sp_rd_data;
   logic [2*CNT_W-1:0] ct_rd_data;
   live_entry_type  live_rd;
   spare_entry_type spare_rd;
   logic [CNT_W-1:0] k_eff;
   logic [CNT_W-1:0] climb_cnt;
   logic            load_last, write_last, rsp_free;

   assign live_rd   = live_entry_type'(lv_rd_data);
   assign spare_rd  = spare_entry_type'(sp_rd_data);
   assign k_eff     = (32'(cfg.bucket_size) > MAX_K) ? CNT_W'(MAX_K) : CNT_W'(cfg.bucket_size);
   assign climb_cnt = cvld_ff ? ct_rd_data[2*CNT_W-1:CNT_W] : '0;
   assign load_last = (idx_ff == SI_W'(SPARE_K - 1));
   assign write_last = load_last;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   kbrt_ram #(.WIDTH(LE_W), .DEPTH(NUM_BUCKETS * MAX_K)) u_live (
      .clock(clock), .wr_en(lv_wr_en), .wr_addr(lv_wr_addr),
      .wr_data(live_lane_ff[idx_ff[LI_W-1:0]]),
      .rd_en(lv_rd_en), .rd_addr(lv_rd_addr), .rd_data(lv_rd_data));

   kbrt_ram #(.WIDTH(SE_W), .DEPTH(NUM_BUCKETS * SPARE_K)) u_spare (
      .clock(clock), .wr_en(sp_wr_en), .wr_addr(sp_wr_addr),
      .wr_data(spare_lane_ff[idx_ff]),
      .rd_en(sp_rd_en), .rd_addr(sp_rd_addr), .rd_data(sp_rd_data));

   kbrt_ram #(.WIDTH(2 * CNT_W), .DEPTH(NUM_BUCKETS)) u_count (
      .clock(clock), .wr_en(ct_wr_en), .wr_addr(ct_wr_addr),
      .wr_data({lc_ff, sc_ff}),
      .rd_en(ct_rd_en), .rd_addr(ct_rd_addr), .rd_data(ct_rd_data));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:   if (!q_empty) state_in = B_CNT;
         B_CNT:    state_in = B_CNTW;
         B_CNTW:   state_in = B_LOAD;
         B_LOAD:   if (load_last) state_in = B_LOADW;
         B_LOADW:  state_in = B_EXEC;
         B_EXEC:   state_in = (ldirty_in || sdirty_in) ? B_WRITE : B_DONE;
         B_WRITE:  if (write_last) state_in = climb_ff ? B_CLIMB : B_DONE;
         B_CLIMB:  state_in = (lowest_ff < BUCKET_W'(NUM_BUCKETS)) ? B_CLIMBW : B_DONE;
         B_CLIMBW: state_in = (climb_cnt == '0) ? B_CLIMB : B_DONE;
         B_DONE:   if (rsp_free) state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   // outputs: queue pop and memory ports
   always_comb begin
      q_pop      = 1'b0;
      lv_rd_en   = 1'b0;
      sp_rd_en   = 1'b0;
      ct_rd_en   = 1'b0;
      lv_wr_en   = 1'b0;
      sp_wr_en   = 1'b0;
      ct_wr_en   = 1'b0;
      lv_rd_addr = LA_W'(32'(cmd_ff.bucket) * MAX_K + 32'(idx_ff));
      sp_rd_addr = SA_W'(32'(cmd_ff.bucket) * SPARE_K + 32'(idx_ff));
      lv_wr_addr = lv_rd_addr;
      sp_wr_addr = sp_rd_addr;
      ct_rd_addr = cmd_ff.bucket[CA_W-1:0];
      ct_wr_addr = cmd_ff.bucket[CA_W-1:0];
      case (state_ff)
         B_IDLE:  q_pop = !q_empty;
         B_CNT:   ct_rd_en = 1'b1;
         B_LOAD: begin
            lv_rd_en = (idx_ff < SI_W'(MAX_K));
            sp_rd_en = 1'b1;
         end
         B_WRITE: begin
            lv_wr_en = ldirty_ff && (idx_ff < SI_W'(MAX_K)) && (CNT_W'(idx_ff) < lc_ff);
            sp_wr_en = sdirty_ff && (CNT_W'(idx_ff) < sc_ff);
            ct_wr_en = (idx_ff == '0);
         end
         B_CLIMB: begin
            ct_rd_en   = (lowest_ff < BUCKET_W'(NUM_BUCKETS));
            ct_rd_addr = lowest_ff[CA_W-1:0];
         end
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      logic            rm_en, app_en, upd_en, sdrop, spop, sapp, h_dec, h_inc;
      logic [LI_W-1:0] rm_idx;
      live_entry_type  app_e, cur, ln;
      spare_entry_type top_e, new_s, sn;
      logic [FAIL_W-1:0] fnew;
      logic [CNT_W-1:0] c1, c1s, sc_m1;
      logic [H_W-1:0]  h1;
      logic [LI_W-1:0] li;

      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      cap_vld_in    = 1'b0;
      cap_idx_in    = idx_ff;
      lc_in         = lc_ff;
      sc_in         = sc_ff;
      hit_in        = hit_ff;
      shit_in       = shit_ff;
      hidx_in       = hidx_ff;
      best_in       = best_ff;
      bestf_in      = bestf_ff;
      live_lane_in  = live_lane_ff;
      spare_lane_in = spare_lane_ff;
      ldirty_in     = ldirty_ff;
      sdirty_in     = sdirty_ff;
      climb_in      = climb_ff;
      healthy_in    = healthy_ff;
      lowest_in     = lowest_ff;
      answer_in     = answer_ff;
      outcome_in    = outcome_ff;
      valid_in      = valid_ff;
      cvld_in       = cvld_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_answer_in = rsp_answer_ff;
      rsp_outcome_in = rsp_outcome_ff;
      rsp_lowest_in = rsp_lowest_ff;

      rm_en  = 1'b0;
      rm_idx = hidx_ff;
      app_en = 1'b0;
      upd_en = 1'b0;
      sdrop  = 1'b0;
      spop   = 1'b0;
      sapp   = 1'b0;
      h_dec  = 1'b0;
      h_inc  = 1'b0;
      cur    = live_lane_ff[hidx_ff];
      sc_m1  = sc_ff - CNT_W'(1);
      top_e  = spare_lane_ff[sc_m1[SI_W-1:0]];
      new_s  = '{id: cmd_ff.id, addr: cmd_ff.addr};
      app_e  = '{id: cmd_ff.id, addr: cmd_ff.addr, fails: '0};
      fnew   = (cur.fails == '1) ? cur.fails : cur.fails + FAIL_W'(1);
      li     = cap_idx_ff[LI_W-1:0];

      // read of the count table, for the bucket or for the lowest-bucket climb
      if (ct_rd_en) cvld_in = valid_ff[ct_rd_addr];

      // streamed bucket entries: keep them and track the searches
      if (cap_vld_ff) begin
         if (cap_idx_ff < SI_W'(MAX_K)) begin
            live_lane_in[li] = live_rd;
            if (CNT_W'(cap_idx_ff) < lc_ff) begin
               if (!hit_ff && live_rd.id == cmd_ff.id) begin
                  hit_in  = 1'b1;
                  hidx_in = li;
               end
               if (cap_idx_ff == '0 || live_rd.fails > bestf_ff) begin
                  best_in  = li;
                  bestf_in = live_rd.fails;
               end
            end
         end
         spare_lane_in[cap_idx_ff] = spare_rd;
         if (CNT_W'(cap_idx_ff) < sc_ff && spare_rd.id == cmd_ff.id) shit_in = 1'b1;
      end

      case (state_ff)
         B_IDLE: if (!q_empty) cmd_in = q_head;
         B_CNTW: begin
            lc_in    = cvld_ff ? ct_rd_data[2*CNT_W-1:CNT_W] : '0;
            sc_in    = cvld_ff ? ct_rd_data[CNT_W-1:0] : '0;
            hit_in   = 1'b0;
            shit_in  = 1'b0;
            bestf_in = '0;
            best_in  = '0;
            idx_in   = '0;
         end
         B_LOAD: begin
            cap_vld_in = 1'b1;
            cap_idx_in = idx_ff;
            if (!load_last) idx_in = idx_ff + SI_W'(1);
         end
         B_EXEC: begin
            answer_in  = 1'b0;
            outcome_in = OC_IGNORED;
            ldirty_in  = 1'b0;
            sdirty_in  = 1'b0;
            climb_in   = 1'b0;
            case (cmd_ff.opcode)
               OP_SEEN: begin
                  answer_in = (healthy_ff == '0);
                  if (hit_ff) begin
                     rm_en = 1'b1; h_dec = (cur.fails == '0);
                     app_en = 1'b1; h_inc = 1'b1;
                     ldirty_in = 1'b1; outcome_in = OC_MOVED;
                  end else if (lc_ff < k_eff) begin
                     app_en = 1'b1; h_inc = 1'b1; ldirty_in = 1'b1;
                     outcome_in = OC_INSERTED;
                     if (cmd_ff.bucket < lowest_ff && cmd_ff.bucket != '0)
                        lowest_in = cmd_ff.bucket;
                  end else if (lc_ff != '0 && bestf_ff != '0) begin
                     rm_en = 1'b1; rm_idx = best_ff;
                     app_en = 1'b1; h_inc = 1'b1; ldirty_in = 1'b1;
                     outcome_in = OC_REPLACED;
                  end else if (shit_ff) begin
                     outcome_in = OC_HAVE;
                  end else begin
                     sdrop = (sc_ff > k_eff) || (sc_ff >= CNT_W'(SPARE_K));
                     sapp = 1'b1; sdirty_in = 1'b1;
                     outcome_in = OC_CACHED;
                  end
               end
               OP_FAILED: begin
                  if (hit_ff && cmd_ff.bucket != '0) begin
                     ldirty_in = 1'b1;
                     h_dec = (cur.fails == '0);
                     if (sc_ff == '0) begin
                        if (fnew >= cfg.max_fail) begin
                           rm_en = 1'b1; climb_in = 1'b1;
                           outcome_in = OC_EVICTED;
                        end else begin
                           upd_en = 1'b1;
                           outcome_in = OC_COUNTED;
                        end
                     end else begin
                        rm_en = 1'b1;
                        app_en = 1'b1; h_inc = 1'b1;
                        app_e = '{id: top_e.id, addr: top_e.addr, fails: '0};
                        spop = 1'b1; sdirty_in = 1'b1;
                        outcome_in = OC_SWAPPED;
                     end
                  end
               end
               OP_QUERY: begin
                  outcome_in = OC_QUERY;
                  answer_in  = (sc_ff < k_eff) && !hit_ff && !shit_ff;
               end
               default: ;
            endcase

            // healthy count: removal first, then the append
            h1 = (h_dec && healthy_ff != '0) ? healthy_ff - H_W'(1) : healthy_ff;
            healthy_in = h1 + H_W'(h_inc);

            // live lanes: remove keeping order, count update, append at the end
            c1 = lc_ff - CNT_W'(rm_en);
            for (int j = 0; j < MAX_K; j++) begin
               ln = live_lane_ff[j];
               if (rm_en && LI_W'(j) >= rm_idx && j < MAX_K - 1)
                  ln = live_lane_ff[(j < MAX_K - 1) ? j + 1 : j];
               if (upd_en && LI_W'(j) == hidx_ff) ln.fails = fnew;
               if (app_en && CNT_W'(j) == c1) ln = app_e;
               live_lane_in[j] = ln;
            end
            lc_in = c1 + CNT_W'(app_en);

            // spare lanes: drop the oldest or take the newest, then append
            c1s = sc_ff - CNT_W'(sdrop || spop);
            for (int j = 0; j < SPARE_K; j++) begin
               sn = spare_lane_ff[j];
               if (sdrop && j < SPARE_K - 1)
                  sn = spare_lane_ff[(j < SPARE_K - 1) ? j + 1 : j];
               if (sapp && CNT_W'(j) == c1s) sn = new_s;
               spare_lane_in[j] = sn;
            end
            sc_in  = c1s + CNT_W'(sapp);
            idx_in = '0;
         end
         B_WRITE: begin
            if (idx_ff == '0) valid_in[cmd_ff.bucket[CA_W-1:0]] = 1'b1;
            if (!write_last) idx_in = idx_ff + SI_W'(1);
         end
         B_CLIMBW: if (climb_cnt == '0) lowest_in = lowest_ff + BUCKET_W'(1);
         B_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_answer_in  = answer_ff;
               rsp_outcome_in = outcome_ff;
               rsp_lowest_in  = lowest_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cap_vld_ff   <= 1'b0;
         healthy_ff   <= '0;
         lowest_ff    <= BUCKET_W'(NUM_BUCKETS);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_vld_ff   <= cap_vld_in;
         healthy_ff   <= healthy_in;
         lowest_ff    <= lowest_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      idx_ff         <= idx_in;
      cap_idx_ff     <= cap_idx_in;
      lc_ff          <= lc_in;
      sc_ff          <= sc_in;
      hit_ff         <= hit_in;
      shit_ff        <= shit_in;
      hidx_ff        <= hidx_in;
      best_ff        <= best_in;
      bestf_ff       <= bestf_in;
      live_lane_ff   <= live_lane_in;
      spare_lane_ff  <= spare_lane_in;
      ldirty_ff      <= ldirty_in;
      sdirty_ff      <= sdirty_in;
      climb_ff       <= climb_in;
      answer_ff      <= answer_in;
      outcome_ff     <= outcome_in;
      cvld_ff        <= cvld_in;
      rsp_answer_ff  <= rsp_answer_in;
      rsp_outcome_ff <= rsp_outcome_in;
      rsp_lowest_ff  <= rsp_lowest_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - BUCKET_W - 1){1'b0}}, rsp_lowest_ff, rsp_answer_ff};
   assign rsp_tuser  = rsp_outcome_ff;

   // a bucket written back never holds more entries than its lists allow
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_WRITE) |-> (lc_ff <= CNT_W'(MAX_K)))
      else $error("live count above MAX_K at write back");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_WRITE) |-> (sc_ff <= CNT_W'(SPARE_K)))
      else $error("spare count above limit at write back");
   // bucket 0 is never the lowest active bucket
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DONE) |-> (lowest_ff != '0 && lowest_ff <= BUCKET_W'(NUM_BUCKETS)))
      else $error("lowest bucket out of range");
   // healthy total changes only in the execute state, by at most one per operation
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != B_EXEC) |=> (healthy_ff == $past(healthy_ff)))
      else $error("healthy total changed outside execute");

endmodule
`default_nettype wire
